// ===== sv/nps_pkg.sv =====
// Shared types and constants for the nonpreemptive priority scheduler.
package nps_pkg;

	localparam int unsigned TIME_W = 21;
	localparam int unsigned SUM_W  = 25;
	localparam logic [TIME_W-1:0] T21_MAX = 21'd2097151;
	localparam logic [SUM_W-1:0]  S25_MAX = 25'd33554431;

	typedef struct packed {
		logic [7:0]  proc_id;
		logic [15:0] arrival_time;
		logic [15:0] burst_time;
		logic [7:0]  prio_level;
		logic        last_process;
	} rec_t;

	typedef struct packed {
		logic [7:0]        out_proc_id;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] wait_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [SUM_W-1:0]  total_wait;
		logic [SUM_W-1:0]  total_turnaround;
		logic              overflow_flag;
		logic              last_result;
	} res_t;

	typedef struct packed {
		logic [7:0]  ent_id;
		logic [15:0] ent_arr;
		logic [15:0] ent_burst;
		logic [7:0]  ent_prio;
	} entry_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_CALC,
		ST_EMIT
	} st_t;

endpackage

// ===== sv/nps_ram.sv =====
// Generic single-port-write, registered-read RAM.
module nps_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/nps_front.sv =====
// Front end: accepts record words into a two-entry queue for the back end.
module nps_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_stall,
	input  nps_pkg::rec_t rec,
	output logic          q_valid,
	output nps_pkg::rec_t q_word,
	input  logic          q_pop
);
	import nps_pkg::*;

	rec_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign rec_stall = (fill_q == 2'd2);
	assign push      = rec_valid && !rec_stall;
	assign pop       = q_pop && q_valid;
	assign q_valid   = (fill_q != 2'd0);
	assign q_word    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/nps_back.sv =====
// Back end: record table, priority scan and result computation.
module nps_back #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  nps_pkg::rec_t q_word,
	output logic          q_pop,
	output logic          res_valid,
	input  logic          res_stall,
	output nps_pkg::res_t res
);
	import nps_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_PROCS);
	localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
	localparam int unsigned ENT_W = $bits(entry_t);

	st_t                 state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_ix_s1;
	logic [MAX_PROCS-1:0] done_q;
	logic [TIME_W-1:0]   clock_q;
	logic                dropped_q;
	logic [SUM_W-1:0]    wsum_q;
	logic [SUM_W-1:0]    tsum_q;

	logic                a_fnd_q;
	entry_t              a_ent_q;
	logic [IDX_W-1:0]    a_ix_q;
	logic                e_fnd_q;
	entry_t              e_ent_q;
	logic [IDX_W-1:0]    e_ix_q;

	logic [7:0]          sel_id_q;
	logic [15:0]         sel_arr_q;
	logic [TIME_W-1:0]   start_q;
	logic [TIME_W-1:0]   finish_q;
	logic [TIME_W-1:0]   wait_q;

	res_t                res_q;
	logic                res_valid_q;

	logic                load_ok;
	logic                ram_we;
	logic                scan_issue;
	logic                scan_end;
	logic                out_free;
	logic                emit;
	logic                is_last;
	logic [ENT_W-1:0]    ram_rdata;
	entry_t              ram_ent;
	entry_t              wr_ent;

	entry_t              sel_ent;
	logic [IDX_W-1:0]    sel_ix;
	logic [TIME_W-1:0]   start_c;
	logic [TIME_W:0]     fin_sum;
	logic [TIME_W-1:0]   finish_c;
	logic [TIME_W-1:0]   tat_c;
	logic [SUM_W:0]      wsum_sum;
	logic [SUM_W:0]      tsum_sum;
	logic [SUM_W-1:0]    wsum_c;
	logic [SUM_W-1:0]    tsum_c;
	logic                arrived;
	logic                a_better;
	logic                e_better;

	assign load_ok    = (count_q < CNT_W'(MAX_PROCS));
	assign q_pop      = (state_q == ST_LOAD) && q_valid;
	assign ram_we     = q_pop && load_ok;
	assign scan_issue = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign scan_end   = (state_q == ST_SCAN) && (rd_idx_q == count_q) && !rd_vld_s1;
	assign out_free   = !res_valid_q || !res_stall;
	assign emit       = (state_q == ST_EMIT) && out_free;
	assign is_last    = ((pos_q + CNT_W'(1)) == count_q);

	assign wr_ent.ent_id    = q_word.proc_id;
	assign wr_ent.ent_arr   = q_word.arrival_time;
	assign wr_ent.ent_burst = q_word.burst_time;
	assign wr_ent.ent_prio  = q_word.prio_level;

	nps_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(wr_ent),
		.re   (scan_issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign ram_ent  = entry_t'(ram_rdata);
	assign arrived  = ({5'd0, ram_ent.ent_arr} <= clock_q);
	assign a_better = !a_fnd_q || (ram_ent.ent_prio < a_ent_q.ent_prio) ||
		((ram_ent.ent_prio == a_ent_q.ent_prio) && (ram_ent.ent_arr < a_ent_q.ent_arr));
	assign e_better = !e_fnd_q || (ram_ent.ent_arr < e_ent_q.ent_arr) ||
		((ram_ent.ent_arr == e_ent_q.ent_arr) && (ram_ent.ent_prio < e_ent_q.ent_prio));

	assign sel_ent  = a_fnd_q ? a_ent_q : e_ent_q;
	assign sel_ix   = a_fnd_q ? a_ix_q : e_ix_q;
	assign start_c  = a_fnd_q ? clock_q : {5'd0, e_ent_q.ent_arr};
	assign fin_sum  = {1'b0, start_c} + {6'd0, sel_ent.ent_burst};
	assign finish_c = (fin_sum > {1'b0, T21_MAX}) ? T21_MAX : fin_sum[TIME_W-1:0];

	assign tat_c    = finish_q - {5'd0, sel_arr_q};
	assign wsum_sum = {1'b0, wsum_q} + {5'd0, wait_q};
	assign tsum_sum = {1'b0, tsum_q} + {5'd0, tat_c};
	assign wsum_c   = (wsum_sum > {1'b0, S25_MAX}) ? S25_MAX : wsum_sum[SUM_W-1:0];
	assign tsum_c   = (tsum_sum > {1'b0, S25_MAX}) ? S25_MAX : tsum_sum[SUM_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (q_pop && q_word.last_process) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) begin
					state_d = is_last ? ST_LOAD : ST_SCAN;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			done_q      <= '0;
			clock_q     <= '0;
			dropped_q   <= 1'b0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			a_fnd_q     <= 1'b0;
			e_fnd_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (res_valid_q && !res_stall && !emit) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (load_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
				rd_idx_q <= '0;
				a_fnd_q  <= 1'b0;
				e_fnd_q  <= 1'b0;
			end
			if (scan_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (rd_vld_s1 && !done_q[rd_ix_s1]) begin
				if (arrived && a_better) begin
					a_fnd_q <= 1'b1;
				end
				if (e_better) begin
					e_fnd_q <= 1'b1;
				end
			end
			if (state_q == ST_CALC) begin
				done_q[sel_ix] <= 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
				rd_idx_q    <= '0;
				a_fnd_q     <= 1'b0;
				e_fnd_q     <= 1'b0;
				if (is_last) begin
					count_q   <= '0;
					pos_q     <= '0;
					done_q    <= '0;
					clock_q   <= '0;
					dropped_q <= 1'b0;
					wsum_q    <= '0;
					tsum_q    <= '0;
				end else begin
					pos_q   <= pos_q + CNT_W'(1);
					clock_q <= finish_q;
					wsum_q  <= wsum_c;
					tsum_q  <= tsum_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ix_s1 <= rd_idx_q[IDX_W-1:0];
		if (rd_vld_s1 && !done_q[rd_ix_s1]) begin
			if (arrived && a_better) begin
				a_ent_q <= ram_ent;
				a_ix_q  <= rd_ix_s1;
			end
			if (e_better) begin
				e_ent_q <= ram_ent;
				e_ix_q  <= rd_ix_s1;
			end
		end
		if (state_q == ST_CALC) begin
			sel_id_q  <= sel_ent.ent_id;
			sel_arr_q <= sel_ent.ent_arr;
			start_q   <= start_c;
			finish_q  <= finish_c;
			wait_q    <= start_c - {5'd0, sel_ent.ent_arr};
		end
		if (emit) begin
			res_q.out_proc_id      <= sel_id_q;
			res_q.start_time       <= start_q;
			res_q.finish_time      <= finish_q;
			res_q.wait_time        <= wait_q;
			res_q.turnaround_time  <= tat_c;
			res_q.total_wait       <= is_last ? wsum_c : '0;
			res_q.total_turnaround <= is_last ? tsum_c : '0;
			res_q.overflow_flag    <= dropped_q;
			res_q.last_result      <= is_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/nonpreemptive_priority_scheduler.sv =====
// Top level of the nonpreemptive priority scheduler.
// Records load at one word per cycle through a two-entry queue unless stalled.
// After the last record, each result of the N loaded records takes one table scan
// through the single RAM read port, then the CALC state and the EMIT state.
// The EMIT state holds while the result output is stalled.
// Reset clears control state; table contents stay undefined until loaded.
module nonpreemptive_priority_scheduler #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_stall,
	input  nps_pkg::rec_t rec,
	output logic          res_valid,
	input  logic          res_stall,
	output nps_pkg::res_t res
);
	import nps_pkg::*;

	logic q_valid;
	rec_t q_word;
	logic q_pop;

	nps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec      (rec),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop)
	);

	nps_back #(
		.MAX_PROCS(MAX_PROCS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

// ===== sim/nps_schedule_check.sv =====
// Checker: predicts the run order of each record set and compares every result word.
`timescale 1ns / 100ps
module nps_schedule_check #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	input  logic          rec_stall,
	input  nps_pkg::rec_t rec,
	input  logic          res_valid,
	input  logic          res_stall,
	input  nps_pkg::res_t res,
	output int            mismatches,
	output int            pending,
	output int            sets_run,
	output int            dropped_sets,
	output int            words_checked
);
	import nps_pkg::*;

	entry_t               slots [MAX_PROCS];
	logic [MAX_PROCS-1:0] ran;
	int unsigned          loaded = 0;
	logic                 dropped = 1'b0;
	res_t                 schedule_q [$];
	int                   miss_count = 0;
	int                   pend_count = 0;
	int                   set_count = 0;
	int                   drop_count = 0;
	int                   word_count = 0;

	assign mismatches    = miss_count;
	assign pending       = pend_count;
	assign sets_run      = set_count;
	assign dropped_sets  = drop_count;
	assign words_checked = word_count;

	task automatic report(input string msg);
		miss_count++;
		if (miss_count <= 60)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got, want);
		if (got !== want)
			report($sformatf("word %0d %s: got %0d, expected %0d", word_count, name, got, want));
	endtask

	task automatic check_word(input res_t want);
		word_count++;
		compare_field("out_proc_id", 32'(res.out_proc_id), 32'(want.out_proc_id));
		compare_field("start_time", 32'(res.start_time), 32'(want.start_time));
		compare_field("finish_time", 32'(res.finish_time), 32'(want.finish_time));
		compare_field("wait_time", 32'(res.wait_time), 32'(want.wait_time));
		compare_field("turnaround_time", 32'(res.turnaround_time),
			32'(want.turnaround_time));
		compare_field("total_wait", 32'(res.total_wait), 32'(want.total_wait));
		compare_field("total_turnaround", 32'(res.total_turnaround),
			32'(want.total_turnaround));
		compare_field("overflow_flag", 32'(res.overflow_flag), 32'(want.overflow_flag));
		compare_field("last_result", 32'(res.last_result), 32'(want.last_result));
	endtask

	task automatic run_set();
		int unsigned now, wsum, tsum, earliest, start, finish, wt, tat, best;
		logic        found;
		res_t        r;
		now = 0;
		wsum = 0;
		tsum = 0;
		ran = '0;
		for (int pos = 0; pos < loaded; pos++) begin
			found = 1'b0;
			earliest = 0;
			for (int k = 0; k < loaded; k++) begin
				if (!ran[k] && (!found || slots[k].ent_arr < earliest)) begin
					earliest = 32'(slots[k].ent_arr);
					found = 1'b1;
				end
			end
			// jump the clock when nothing has arrived yet
			if (now < earliest)
				now = earliest;
			found = 1'b0;
			best = 0;
			for (int k = 0; k < loaded; k++) begin
				if (!ran[k] && slots[k].ent_arr <= now && (!found
						|| slots[k].ent_prio < slots[best].ent_prio
						|| (slots[k].ent_prio == slots[best].ent_prio
						&& slots[k].ent_arr < slots[best].ent_arr))) begin
					best = k;
					found = 1'b1;
				end
			end
			start = (now > T21_MAX) ? T21_MAX : now;
			finish = (start + slots[best].ent_burst > T21_MAX) ? T21_MAX
				: start + slots[best].ent_burst;
			wt = start - slots[best].ent_arr;
			tat = finish - slots[best].ent_arr;
			ran[best] = 1'b1;
			now = finish;
			wsum = (wsum + wt > S25_MAX) ? S25_MAX : wsum + wt;
			tsum = (tsum + tat > S25_MAX) ? S25_MAX : tsum + tat;
			r = '0;
			r.out_proc_id = slots[best].ent_id;
			r.start_time = TIME_W'(start);
			r.finish_time = TIME_W'(finish);
			r.wait_time = TIME_W'(wt);
			r.turnaround_time = TIME_W'(tat);
			r.overflow_flag = dropped;
			if (pos == loaded - 1) begin
				r.total_wait = SUM_W'(wsum);
				r.total_turnaround = SUM_W'(tsum);
				r.last_result = 1'b1;
			end
			schedule_q.push_back(r);
		end
	endtask

	task automatic take_record(input rec_t w);
		if (loaded < MAX_PROCS) begin
			slots[loaded] = {w.proc_id, w.arrival_time, w.burst_time, w.prio_level};
			loaded++;
		end else
			dropped = 1'b1;
		if (w.last_process) begin
			run_set();
			set_count++;
			if (dropped)
				drop_count++;
			loaded = 0;
			dropped = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded = 0;
			dropped = 1'b0;
			schedule_q.delete();
			pend_count <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (schedule_q.size() == 0)
					report($sformatf("result for process %0d with nothing pending",
						res.out_proc_id));
				else
					check_word(schedule_q.pop_front());
			end
			if (rec_valid && !rec_stall)
				take_record(rec);
			pend_count <= schedule_q.size();
		end
	end

endmodule

// ===== sim/nonpreemptive_priority_scheduler_tb.sv =====
// Testbench top: drives record sets and result stalls, and gives the verdict.
`timescale 1ns / 100ps
module nonpreemptive_priority_scheduler_tb;
	import nps_pkg::*;

	localparam int unsigned PROCS = 16;
	localparam int RECORDS      = 300;
	localparam int HOLD_AT      = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * (PROCS + 4) + 10;

	typedef enum int {
		MIX_CROWDED,
		MIX_SPREAD,
		MIX_WILD
	} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rec_valid = 1'b0;
	logic rec_stall;
	rec_t rec = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	int   mismatches, pending, sets_run, dropped_sets, words_checked;
	int   records_sent = 0;
	int   results_taken = 0;
	logic quiet_tx = 1'b0;

	always #5 clk = ~clk;

	nonpreemptive_priority_scheduler #(
		.MAX_PROCS(PROCS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	nps_schedule_check #(
		.MAX_PROCS(PROCS)
	) schedule_check (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.mismatches(mismatches),
		.pending(pending),
		.sets_run(sets_run),
		.dropped_sets(dropped_sets),
		.words_checked(words_checked)
	);

	task automatic send_record(input logic [7:0] id, input logic [15:0] arr, burst,
			input logic [7:0] prio, input logic last);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_valid <= 1'b1;
		rec <= {id, arr, burst, prio, last};
		@(posedge clk);
		while (rec_stall)
			@(posedge clk);
		records_sent++;
	endtask

	task automatic send_set(input int count, input mix_t mix);
		logic [15:0] arr, burst;
		logic [7:0]  prio;
		quiet_tx = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			case (mix)
				MIX_CROWDED: begin
					arr = 16'($urandom_range(0, 200));
					burst = 16'($urandom_range(0, 100));
					prio = 8'($urandom_range(0, 3));
				end
				MIX_SPREAD: begin
					arr = 16'($urandom_range(0, 65535));
					burst = 16'($urandom_range(0, 300));
					prio = 8'($urandom);
				end
				default: begin
					arr = 16'($urandom);
					burst = 16'($urandom);
					prio = 8'($urandom);
				end
			endcase
			send_record(8'($urandom), arr, burst, prio, i == count - 1);
		end
	endtask

	task automatic drain_results();
		rec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int   pick, count;
		logic paused;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_record(8'd0, 16'd0, 16'd0, 8'd0, 1'b1);
		send_record(8'd255, 16'd65535, 16'd65535, 8'd255, 1'b1);
		// equal keys fall back to load order; earlier arrival beats it; idle jump
		send_record(8'd10, 16'd100, 16'd50, 8'd5, 1'b0);
		send_record(8'd11, 16'd100, 16'd20, 8'd5, 1'b0);
		send_record(8'd12, 16'd40, 16'd30, 8'd5, 1'b0);
		send_record(8'd13, 16'd5000, 16'd10, 8'd0, 1'b0);
		send_record(8'd14, 16'd120, 16'd0, 8'd9, 1'b0);
		send_record(8'd15, 16'd0, 16'd15, 8'd200, 1'b1);
		// overfill the table, dropping the closing record
		for (int i = 0; i <= PROCS; i++)
			send_record(8'(100 + i), 16'(i * 7), 16'(10 + i), 8'((i * 5) % 7), i == PROCS);

		while (records_sent < RECORDS) begin
			if (!paused && records_sent >= RECORDS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 11);
			if (pick == 0)
				count = $urandom_range(PROCS + 1, PROCS + 4);
			else if (pick < 3)
				count = $urandom_range(7, PROCS);
			else
				count = $urandom_range(1, 6);
			send_set(count, mix_t'($urandom_range(0, 2)));
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d records in %0d sets, %0d of them overfilling the table;",
			records_sent, sets_run, dropped_sets);
		$display("checked %0d scheduled results under random stalls on both sides.",
			words_checked);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int   gap;
		logic quiet_rx;
		quiet_rx = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				results_taken++;
				if (results_taken % 24 == 0)
					quiet_rx = ($urandom_range(0, 2) == 0);
				if (results_taken == HOLD_AT)
					gap = HOLD_CYCLES;
				else
					gap = quiet_rx ? 0 : $urandom_range(0, 3);
				if (gap > 0) begin
					res_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					res_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
